### rtl/core/qau_pkg.sv
// qau_pkg: command codes and fixed constants of the quaternion arithmetic unit
// no dependencies
`default_nettype none

package qau_pkg;

  typedef enum logic [2:0] {
    CMD_MUL  = 3'd0,
    CMD_NMUL = 3'd1,
    CMD_NORM = 3'd2,
    CMD_MAG  = 3'd3,
    CMD_ROT  = 3'd4,
    CMD_MAT  = 3'd5
  } cmd_t;

  // matrix rows go out as three words
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;

endpackage

`default_nettype wire

### rtl/core/qau_if.sv
// qau channel interfaces: operand words in, result words out
// valid/ready handshake, widths follow WORD_BITS; no package dependency
`default_nettype none

interface quat_in_if #(parameter int WORD_BITS = 16) ();
  logic                        valid;
  logic                        ready;
  logic [2:0]                  cmd;
  logic signed [WORD_BITS-1:0] a_x;
  logic signed [WORD_BITS-1:0] a_y;
  logic signed [WORD_BITS-1:0] a_z;
  logic signed [WORD_BITS-1:0] a_w;
  logic signed [WORD_BITS-1:0] b_x;
  logic signed [WORD_BITS-1:0] b_y;
  logic signed [WORD_BITS-1:0] b_z;
  logic signed [WORD_BITS-1:0] b_w;

  modport source (output valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink (input valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                output ready);
endinterface

interface quat_res_if #(parameter int WORD_BITS = 16) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_x;
  logic signed [WORD_BITS-1:0] res_y;
  logic signed [WORD_BITS-1:0] res_z;
  logic signed [WORD_BITS-1:0] res_w;
  logic                        last;
  logic                        zero_magnitude;

  modport source (output valid, res_x, res_y, res_z, res_w, last, zero_magnitude,
                  input ready);
  modport sink (input valid, res_x, res_y, res_z, res_w, last, zero_magnitude,
                output ready);
endinterface

`default_nettype wire

### rtl/core/quaternion_arithmetic_unit.sv
// quaternion_arithmetic_unit: pipelined fixed-point quaternion product, normalize,
// magnitude, vector rotation and rotation matrix; uses qau_pkg and qau_if
//
// channel  | dir | words per item          | payload
// in_ch    | in  | 1                       | cmd, a_x..a_w, b_x..b_w
// res_ch   | out | 1, or 3 for matrix      | res_x..res_w, last, zero_magnitude
//
// an item passes the product stages, the square-root stages (one root bit each), the
// divider stages (one quotient bit each) and the output register. a new word is taken
// every cycle unless res_ch stalls or a matrix is going out; a matrix holds the output
// register until its three rows are out. one global enable moves every stage, so a
// stall on res_ch freezes the whole pipe and nothing is lost or repeated.
// rst is synchronous and clears the valid bits and the matrix row count only.
`default_nettype none

module quaternion_arithmetic_unit
  import qau_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 12
) (
  input  wire logic  clk,
  input  wire logic  rst,
  quat_in_if.sink    in_ch,
  quat_res_if.source res_ch
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int MW = (W > F) ? W : F;
  localparam int AW = 2 * MW + 4;   // product-sum accumulator
  localparam int SW = 2 * W + 1;    // sum of four squares
  localparam int TW = 2 * W + 3;    // square-root remainder and trial
  localparam int RW = W + 1;        // root / magnitude
  localparam int QW = F + 1;        // quotient bits
  localparam int NW = W + F + 1;    // dividend
  localparam int DW = NW + RW;      // divider compare width
  localparam int CW = QW + W + 1;   // quotient saturation compare

  typedef logic signed [W-1:0]     word_t;
  typedef logic signed [2*W-1:0]   prod_t;
  typedef logic signed [AW-1:0]    acc_t;
  typedef logic [SW-1:0]           sq_t;
  typedef acc_t [3:0]              acc4_t;

  typedef struct packed {
    logic [2:0]  cmd;
    word_t [3:0] q;   // result words, or the quaternion to normalize
    word_t [8:0] m;   // matrix entries, row major
  } side_t;

  localparam word_t WMAX_W = word_t'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam word_t WMIN_W = word_t'(-(64'sd1 <<< (W - 1)));
  localparam logic signed [AW:0] WMAX_X = (AW+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [AW:0] WMIN_X = (AW+1)'(-(64'sd1 <<< (W - 1)));
  localparam logic signed [AW:0] HALF_X = (AW+1)'(1) << (F - 1);
  localparam acc_t ONE_A = acc_t'(1) << (2 * F);
  localparam logic [CW-1:0] LIM_POS = CW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic [CW-1:0] LIM_NEG = CW'(1) << (W - 1);
  localparam logic [RW-1:0] WMAX_R = RW'((64'sd1 <<< (W - 1)) - 64'sd1);

  // saturating negate
  function automatic word_t neg_sat(input word_t v);
    neg_sat = (v == WMIN_W) ? WMAX_W : -v;
  endfunction

  function automatic acc_t ext(input prod_t p);
    ext = acc_t'($signed(p));
  endfunction

  // add half lsb, floor shift, saturate to word
  function automatic word_t rnd(input acc_t acc);
    logic signed [AW:0] s;
    logic signed [AW:0] h;
    s = (AW+1)'(acc) + HALF_X;
    h = s >>> F;
    if (h > WMAX_X) begin
      rnd = WMAX_W;
    end else if (h < WMIN_X) begin
      rnd = WMIN_W;
    end else begin
      rnd = h[W-1:0];
    end
  endfunction

  // hamilton product sums, p[4*i+j] = l[i]*r[j]
  function automatic acc4_t ham(input prod_t [15:0] p);
    acc4_t o;
    o[0] = ext(p[3]) + ext(p[6]) - ext(p[9]) + ext(p[12]);
    o[1] = ext(p[7]) + ext(p[8]) + ext(p[13]) - ext(p[2]);
    o[2] = ext(p[1]) - ext(p[4]) + ext(p[11]) + ext(p[14]);
    o[3] = ext(p[15]) - ext(p[0]) - ext(p[5]) - ext(p[10]);
    ham = o;
  endfunction

  function automatic sq_t sqv(input prod_t p);
    sqv = SW'(p[2*W-2:0]);
  endfunction

  logic adv;
  logic out_last;

  // ---------------------------------------------------------------- stage 0
  // operand select: rotate first forms v * conj(a)
  word_t [3:0] ain;
  word_t [3:0] bin;
  word_t [3:0] lsel;
  word_t [3:0] rsel;

  assign ain = {in_ch.a_w, in_ch.a_z, in_ch.a_y, in_ch.a_x};
  assign bin = {in_ch.b_w, in_ch.b_z, in_ch.b_y, in_ch.b_x};

  always_comb begin
    if (in_ch.cmd == CMD_ROT) begin
      lsel = {word_t'(0), bin[2], bin[1], bin[0]};
      rsel = {ain[3], neg_sat(ain[2]), neg_sat(ain[1]), neg_sat(ain[0])};
    end else begin
      lsel = ain;
      rsel = bin;
    end
  end

  logic        v0;
  logic [2:0]  cmd0;
  word_t [3:0] a0;
  word_t [3:0] l0;
  word_t [3:0] r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0 <= in_ch.cmd;
      a0   <= ain;
      l0   <= lsel;
      r0   <= rsel;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // first products, matrix products and squares of a
  logic         v1;
  logic [2:0]   cmd1;
  word_t [3:0]  a1;
  prod_t [15:0] p1;
  prod_t [9:0]  mp1;   // xx yy zz xy xz yz xw yw zw ww

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= cmd0;
      a1   <= a0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p1[4*i+j] <= l0[i] * r0[j];
        end
      end
      mp1[0] <= a0[0] * a0[0];
      mp1[1] <= a0[1] * a0[1];
      mp1[2] <= a0[2] * a0[2];
      mp1[3] <= a0[0] * a0[1];
      mp1[4] <= a0[0] * a0[2];
      mp1[5] <= a0[1] * a0[2];
      mp1[6] <= a0[0] * a0[3];
      mp1[7] <= a0[1] * a0[3];
      mp1[8] <= a0[2] * a0[3];
      mp1[9] <= a0[3] * a0[3];
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic        v2;
  logic [2:0]  cmd2;
  word_t [3:0] a2;
  acc4_t       acc2;
  acc_t [8:0]  mac2;
  sq_t         asq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2    <= cmd1;
      a2      <= a1;
      acc2    <= ham(p1);
      mac2[0] <= ONE_A - (ext(mp1[1]) <<< 1) - (ext(mp1[2]) <<< 1);
      mac2[1] <= (ext(mp1[3]) <<< 1) - (ext(mp1[8]) <<< 1);
      mac2[2] <= (ext(mp1[4]) <<< 1) + (ext(mp1[7]) <<< 1);
      mac2[3] <= (ext(mp1[3]) <<< 1) + (ext(mp1[8]) <<< 1);
      mac2[4] <= ONE_A - (ext(mp1[0]) <<< 1) - (ext(mp1[2]) <<< 1);
      mac2[5] <= (ext(mp1[5]) <<< 1) - (ext(mp1[6]) <<< 1);
      mac2[6] <= (ext(mp1[4]) <<< 1) - (ext(mp1[7]) <<< 1);
      mac2[7] <= (ext(mp1[5]) <<< 1) + (ext(mp1[6]) <<< 1);
      mac2[8] <= ONE_A - (ext(mp1[0]) <<< 1) - (ext(mp1[1]) <<< 1);
      asq2    <= sqv(mp1[0]) + sqv(mp1[1]) + sqv(mp1[2]) + sqv(mp1[9]);
    end
  end

  // ---------------------------------------------------------------- stage 3
  // round first product and matrix entries
  logic        v3;
  logic [2:0]  cmd3;
  word_t [3:0] a3;
  word_t [3:0] t3;
  word_t [8:0] mr3;
  sq_t         asq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd3 <= cmd2;
      a3   <= a2;
      asq3 <= asq2;
      for (int i = 0; i < 4; i++) begin
        t3[i] <= rnd(acc2[i]);
      end
      for (int i = 0; i < 9; i++) begin
        mr3[i] <= rnd(mac2[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 4
  // second products a * t, and squares of t
  logic         v4;
  logic [2:0]   cmd4;
  word_t [3:0]  a4;
  word_t [3:0]  t4;
  word_t [8:0]  mr4;
  sq_t          asq4;
  prod_t [15:0] p4;
  prod_t [3:0]  tq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd4 <= cmd3;
      a4   <= a3;
      t4   <= t3;
      mr4  <= mr3;
      asq4 <= asq3;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p4[4*i+j] <= a3[i] * t3[j];
        end
        tq4[i] <= t3[i] * t3[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic        v5;
  logic [2:0]  cmd5;
  word_t [3:0] a5;
  word_t [3:0] t5;
  word_t [8:0] mr5;
  sq_t         asq5;
  sq_t         tsq5;
  acc4_t       acc5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd5 <= cmd4;
      a5   <= a4;
      t5   <= t4;
      mr5  <= mr4;
      asq5 <= asq4;
      tsq5 <= sqv(tq4[0]) + sqv(tq4[1]) + sqv(tq4[2]) + sqv(tq4[3]);
      acc5 <= ham(p4);
    end
  end

  // ---------------------------------------------------------------- stage 6
  // pick the quaternion that goes on, and the sum whose root is taken
  side_t side6;

  always_comb begin
    side6.cmd = cmd5;
    side6.m   = mr5;
    if (cmd5 == CMD_ROT) begin
      for (int i = 0; i < 4; i++) begin
        side6.q[i] = rnd(acc5[i]);
      end
    end else if (cmd5 == CMD_MUL || cmd5 == CMD_NMUL) begin
      side6.q = t5;
    end else begin
      side6.q = a5;
    end
  end

  // square root, one root bit per stage
  logic [RW:0]    sv;
  side_t          sside [0:RW];
  logic [TW-1:0]  srem  [0:RW];
  logic [RW-1:0]  sroot [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sside[0] <= side6;
      srem[0]  <= TW'((cmd5 == CMD_NMUL) ? tsq5 : asq5);
      sroot[0] <= '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [TW-1:0] trial;

    assign trial = (TW'(sroot[k]) << (B + 1)) + (TW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sside[k+1] <= sside[k];
        if (srem[k] >= trial) begin
          srem[k+1]  <= srem[k] - trial;
          sroot[k+1] <= sroot[k] | (RW'(1) << B);
        end else begin
          srem[k+1]  <= srem[k];
          sroot[k+1] <= sroot[k];
        end
      end
    end
  end

  // round the root to nearest
  logic          rv;
  side_t         rside;
  logic [RW-1:0] rmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (adv) begin
      rv <= sv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rside <= sside[RW];
      rmag  <= sroot[RW] + RW'(srem[RW] > TW'(sroot[RW]));
    end
  end

  // divider: dividend set-up, then one quotient bit per stage, four lanes
  logic [QW:0]    dv;
  side_t          dside [0:QW];
  logic [RW-1:0]  dmag  [0:QW];
  logic [3:0]     dneg  [0:QW];
  logic [NW-1:0]  drem  [0:QW][0:3];
  logic [QW-1:0]  dquo  [0:QW][0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= rv;
    end
  end

  // magnitude taken unsigned so the most negative word gives 2^(W-1)
  always_ff @(posedge clk) begin
    if (adv) begin
      dside[0] <= rside;
      dmag[0]  <= rmag;
      for (int j = 0; j < 4; j++) begin
        dneg[0][j] <= rside.q[j][W-1];
        drem[0][j] <= (NW'($unsigned(rside.q[j][W-1] ? -rside.q[j] : rside.q[j]))
                       << F) + NW'(rmag >> 1);
        dquo[0][j] <= '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [DW-1:0] dvs;

    assign dvs = DW'(dmag[k]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dside[k+1] <= dside[k];
        dmag[k+1]  <= dmag[k];
        dneg[k+1]  <= dneg[k];
        for (int j = 0; j < 4; j++) begin
          if (DW'(drem[k][j]) >= dvs) begin
            drem[k+1][j] <= NW'(DW'(drem[k][j]) - dvs);
            dquo[k+1][j] <= dquo[k][j] | (QW'(1) << B);
          end else begin
            drem[k+1][j] <= drem[k][j];
            dquo[k+1][j] <= dquo[k][j];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- result
  side_t         fside;
  word_t [3:0]   nq;
  word_t [3:0]   fw;
  logic          fzm;
  logic [CW-1:0] qsat [0:3];
  logic [CW-1:0] qlim [0:3];

  assign fside = dside[QW];

  // sign back on, saturate against the word range
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      qlim[j] = dneg[QW][j] ? LIM_NEG : LIM_POS;
      qsat[j] = (CW'(dquo[QW][j]) > qlim[j]) ? qlim[j] : CW'(dquo[QW][j]);
      nq[j]   = dneg[QW][j] ? word_t'(-qsat[j]) : word_t'(qsat[j]);
    end
  end

  always_comb begin
    fw  = '0;
    fzm = 1'b0;
    case (fside.cmd)
      CMD_MUL, CMD_ROT: begin
        fw = fside.q;
      end
      CMD_NMUL, CMD_NORM: begin
        if (dmag[QW] == '0) begin
          fzm = 1'b1;
        end else begin
          fw = nq;
        end
      end
      CMD_MAG: begin
        fw[3] = (dmag[QW] > WMAX_R) ? WMAX_W : word_t'(dmag[QW]);
      end
      default: begin
        fw = '0;
      end
    endcase
  end

  // output register, matrix rows stepped out of it
  logic        ov;
  logic        omat;
  logic        ozm;
  logic [1:0]  orow;
  word_t [3:0] ow;
  word_t [8:0] om;

  assign out_last = !omat || (orow == ROW_LAST);
  assign adv      = !ov || (res_ch.ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov   <= 1'b0;
      orow <= ROW_FIRST;
    end else if (adv) begin
      ov   <= dv[QW];
      orow <= ROW_FIRST;
    end else if (res_ch.ready) begin
      orow <= orow + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      omat <= (fside.cmd == CMD_MAT);
      ozm  <= fzm;
      ow   <= fw;
      om   <= fside.m;
    end
  end

  always_comb begin
    if (omat) begin
      case (orow)
        ROW_FIRST: begin
          res_ch.res_x = om[0];
          res_ch.res_y = om[1];
          res_ch.res_z = om[2];
        end
        2'd1: begin
          res_ch.res_x = om[3];
          res_ch.res_y = om[4];
          res_ch.res_z = om[5];
        end
        default: begin
          res_ch.res_x = om[6];
          res_ch.res_y = om[7];
          res_ch.res_z = om[8];
        end
      endcase
      res_ch.res_w = '0;
    end else begin
      res_ch.res_x = ow[0];
      res_ch.res_y = ow[1];
      res_ch.res_z = ow[2];
      res_ch.res_w = ow[3];
    end
  end

  assign res_ch.valid          = ov;
  assign res_ch.last           = out_last;
  assign res_ch.zero_magnitude = ozm;
  assign in_ch.ready           = adv;

endmodule

`default_nettype wire

### rtl/core/qau_checker.sv
// qau_checker: assertions on the result port of quaternion_arithmetic_unit
// bound to the top level below; no package dependency
`default_nettype none

module qau_checker #(
  parameter int WORD_BITS = 16
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic signed [WORD_BITS-1:0] res_x,
  input wire logic signed [WORD_BITS-1:0] res_y,
  input wire logic signed [WORD_BITS-1:0] res_z,
  input wire logic signed [WORD_BITS-1:0] res_w,
  input wire logic                        last,
  input wire logic                        zero_magnitude
);

  // no word right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({res_x, res_y, res_z, res_w, last, zero_magnitude}))
    else $error("stalled result word changed");

  // zero magnitude gives an all-zero single word
  a_zero_mag: assert property (@(posedge clk) disable iff (rst)
    res_valid && zero_magnitude |->
      res_x == '0 && res_y == '0 && res_z == '0 && res_w == '0 && last)
    else $error("zero magnitude word not cleared");

  // only matrix rows are not last: w zero, no flag
  a_row_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> res_w == '0 && !zero_magnitude)
    else $error("matrix row with w or flag set");

  // the next matrix row follows at once
  a_row_follow: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !last |=> res_valid)
    else $error("matrix row missing");

endmodule

bind quaternion_arithmetic_unit qau_checker #(.WORD_BITS(WORD_BITS)) u_qau_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res_ch.valid),
  .res_ready      (res_ch.ready),
  .res_x          (res_ch.res_x),
  .res_y          (res_ch.res_y),
  .res_z          (res_ch.res_z),
  .res_w          (res_ch.res_w),
  .last           (res_ch.last),
  .zero_magnitude (res_ch.zero_magnitude)
);

`default_nettype wire
